### hdl/ttce_pkg.sv
// Package for the two-thread execute block: opcodes, action, error, flag and jump codes, sizes, control structs.
// No dependencies.
`timescale 1ns / 1ps
package ttce_pkg;
    localparam int DATA_DEPTH_DEF = 256;
    localparam int WORD_WIDTH_DEF = 16;
    localparam int NUM_REGS = 8;
    localparam int MEM_BASE = 16384;

    typedef enum logic [3:0] {
        OP_HALT = 4'd0, OP_MOV = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
        OP_MUL = 4'd4, OP_DIV = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7,
        OP_NOT = 4'd8, OP_CMP = 4'd9, OP_JMP = 4'd10, OP_IN = 4'd11,
        OP_OUT = 4'd12, OP_LOCK = 4'd13, OP_UNLOCK = 4'd14, OP_SLEEP = 4'd15
    } op_t;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_PRINT = 3'd1;
    localparam logic [2:0] ACT_LOCK = 3'd2;
    localparam logic [2:0] ACT_UNLOCK = 3'd3;
    localparam logic [2:0] ACT_SLEEP = 3'd4;
    localparam logic [2:0] ACT_HALT = 3'd5;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ADDR = 2'd2;

    localparam logic [1:0] FLAG_EQ = 2'd0;
    localparam logic [1:0] FLAG_GT = 2'd1;
    localparam logic [1:0] FLAG_LT = 2'd2;

    localparam logic [3:0] JC_ALWAYS = 4'd0;
    localparam logic [3:0] JC_EQ = 4'd1;
    localparam logic [3:0] JC_GT = 4'd2;

    localparam logic [3:0] SRC_IMM = 4'd0;
    localparam logic [3:0] SRC_LOAD_MIN = 4'd5;

    typedef struct packed {
        logic load;     // capture input item, read registers
        logic addr;     // compute memory address, issue read
        logic exec;     // evaluate operation
        logic div_start;
        logic commit;   // write back, update thread state
    } ttce_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic is_div;
    } ttce_sts_t;
endpackage

### hdl/ttce_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ttce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/ttce_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing.
`timescale 1ns / 1ps
module ttce_div #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic [W-1:0] quot
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  rem_reg, rem_next, q_reg, q_next, d_reg, d_next;
    logic          neg_reg, neg_next, busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    trial;
    logic [W-1:0]  rsh;

    assign busy = busy_reg;
    assign quot = neg_reg ? W'(-q_reg) : q_reg;
    assign rsh = {rem_reg[W-2:0], q_reg[W-1]};
    assign trial = {1'b0, rsh} - {1'b0, d_reg};

    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            q_next = num[W-1] ? W'(-num) : num;
            d_next = den[W-1] ? W'(-den) : den;
            neg_next = num[W-1] ^ den[W-1];
            busy_next = 1'b1;
            cnt_next = CW'(W);
        end
        else if (busy_reg)
        begin
            // rem_reg top bit is always clear, so rsh fits W bits
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rsh;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end
endmodule

### hdl/ttce_dp.sv
// Datapath: register files, thread state, shared data memory, ALU, divider.
// Depends on ttce_pkg, ttce_ram, ttce_div.
`timescale 1ns / 1ps
module ttce_dp #(
    parameter int DATA_DEPTH = ttce_pkg::DATA_DEPTH_DEF,
    parameter int WORD_WIDTH = ttce_pkg::WORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ttce_pkg::ttce_cmd_t cmd,
    output ttce_pkg::ttce_sts_t sts,
    input  logic [79:0]        in_data,
    output logic [39:0]        out_data,
    output logic               clr_busy
);
    import ttce_pkg::*;
    localparam int W = WORD_WIDTH;
    localparam int AW = $clog2(DATA_DEPTH);
    localparam int CW = $clog2(DATA_DEPTH + 1);

    logic [W-1:0]  rf_reg [2*NUM_REGS];
    logic [15:0]   pc_reg [2];
    logic [31:0]   ir_reg [2];
    logic [1:0]    flag_reg [2];

    logic [79:0]   it_reg;
    logic          t;
    logic [3:0]    fn, src;
    logic [15:0]   imm;
    logic [2:0]    di, si;
    logic [3:0]    ds, ss;
    logic [W-1:0]  dv_reg, sv_reg, opnd, res_reg, res_next, prod_reg;
    logic [W-1:0]  wb;
    logic          aok_reg, aok_next;
    logic [AW-1:0] maddr_reg, maddr_next;
    logic [W-1:0]  abase;
    logic [W:0]    diff;
    logic [W-1:0]  q;
    logic [W-1:0]  mrd;
    logic          mwe;
    logic [AW-1:0] mad;
    logic [W-1:0]  mwd;
    logic [CW-1:0] clr_reg;
    logic          usemem;
    logic          rwe, mwe_c;
    logic [1:0]    err, flag_new;
    logic [15:0]   npc;
    logic [2:0]    act;
    logic [15:0]   aval;
    logic          take;
    logic [W-1:0]  divq;

    assign t = it_reg[0];
    assign fn = it_reg[4:1];
    assign src = it_reg[12:9];
    assign imm = it_reg[28:13];
    assign di = 3'(it_reg[8:5] + 4'd7);
    assign si = 3'(src + 4'd7);
    assign ds = {t, di};
    assign ss = {t, si};

    // address register: dest for store/(mov src 1..4), src otherwise
    assign abase = (fn == OP_MOV && src != SRC_IMM && src < SRC_LOAD_MIN) ? dv_reg : sv_reg;
    assign diff = {abase[W-1], abase} - (W+1)'(MEM_BASE);
    assign q = diff[W] ? W'(-(W'(-diff[W-1:0]) >> 1)) : W'(diff[W-1:0] >> 1);

    always_comb
    begin
        aok_next = aok_reg;
        maddr_next = maddr_reg;
        if (cmd.addr)
        begin
            aok_next = !q[W-1] && (q < W'(DATA_DEPTH));
            maddr_next = AW'(q);
        end
    end

    assign clr_busy = (clr_reg != CW'(DATA_DEPTH));
    assign mad = clr_busy ? AW'(clr_reg) : (cmd.addr ? AW'(q) : maddr_reg);
    assign mwe = clr_busy || mwe_c;
    assign mwd = clr_busy ? '0 : res_reg;

    ttce_ram #(.WIDTH(W), .DEPTH(DATA_DEPTH)) u_mem (
        .clk(clk), .we(mwe), .addr(mad), .wdata(mwd), .rdata(mrd)
    );

    assign usemem = (src != SRC_IMM);
    assign opnd = (fn >= OP_ADD && fn <= OP_CMP && usemem) ? mrd : W'($signed(imm));

    ttce_div #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dv_reg), .den(opnd),
        .busy(sts.div_busy), .quot(divq)
    );
    assign sts.is_div = (fn == OP_DIV) && !(usemem && !aok_reg) && (opnd != '0);

    always_comb
    begin
        res_next = res_reg;
        if (cmd.exec)
        begin
            unique case (fn)
                OP_MOV: res_next = (src == SRC_IMM) ? W'($signed(imm))
                                 : (src >= SRC_LOAD_MIN ? mrd : sv_reg);
                OP_ADD: res_next = dv_reg + opnd;
                OP_SUB: res_next = dv_reg - opnd;
                OP_AND: res_next = W'((dv_reg != '0) && (opnd != '0));
                OP_OR: res_next = W'((dv_reg != '0) || (opnd != '0));
                OP_NOT: res_next = usemem ? W'(opnd == '0) : W'(dv_reg == '0);
                OP_IN: res_next = W'($signed(it_reg[76:61]));
                default: res_next = res_reg;
            endcase
        end
    end

    assign wb = (fn == OP_MUL) ? prod_reg : ((fn == OP_DIV) ? divq : res_reg);

    always_comb
    begin
        err = ERR_NONE;
        if (((fn >= OP_ADD && fn <= OP_CMP) || fn == OP_MOV) && usemem && !aok_reg)
        begin
            err = ERR_ADDR;
        end
        else if (fn == OP_DIV && opnd == '0)
        begin
            err = ERR_DIV0;
        end
        flag_new = flag_reg[t];
        if (fn == OP_CMP && err == ERR_NONE)
        begin
            flag_new = (dv_reg == opnd) ? FLAG_EQ
                     : ($signed(dv_reg) > $signed(opnd) ? FLAG_GT : FLAG_LT);
        end
        priority if (src == JC_ALWAYS)
            take = 1'b1;
        else if (src == JC_EQ)
            take = flag_reg[t] == FLAG_EQ;
        else if (src == JC_GT)
            take = flag_reg[t] == FLAG_GT;
        else
            take = flag_reg[t] == FLAG_LT;
        npc = (fn == OP_JMP && take) ? pc_reg[t] + imm : pc_reg[t] + 16'd4;
        act = ACT_NONE;
        aval = '0;
        unique case (fn)
            OP_HALT: act = ACT_HALT;
            OP_OUT:
            begin
                act = ACT_PRINT;
                aval = dv_reg[15:0];
            end
            OP_LOCK: act = ACT_LOCK;
            OP_UNLOCK: act = ACT_UNLOCK;
            OP_SLEEP:
            begin
                act = ACT_SLEEP;
                aval = imm;
            end
            default: act = ACT_NONE;
        endcase
        rwe = 1'b0;
        mwe_c = 1'b0;
        if (cmd.commit && err == ERR_NONE)
        begin
            unique case (fn)
                OP_MOV:
                begin
                    rwe = (src == SRC_IMM) || (src >= SRC_LOAD_MIN);
                    mwe_c = !rwe;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_IN: rwe = 1'b1;
                OP_NOT:
                begin
                    rwe = !usemem;
                    mwe_c = usemem;
                end
                default: rwe = 1'b0;
            endcase
        end
    end

    assign out_data = {err, flag_new, aval, act, npc, t};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
            pc_reg[0] <= '0;
            pc_reg[1] <= '0;
            ir_reg[0] <= '0;
            ir_reg[1] <= '0;
            flag_reg[0] <= FLAG_EQ;
            flag_reg[1] <= FLAG_EQ;
            clr_reg <= '0;
        end
        else
        begin
            if (clr_busy)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (rwe)
            begin
                rf_reg[ds] <= wb;
            end
            if (cmd.commit)
            begin
                pc_reg[t] <= npc;
                ir_reg[t] <= it_reg[60:29];
                flag_reg[t] <= flag_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= in_data;
        end
        dv_reg <= rf_reg[ds];
        sv_reg <= rf_reg[ss];
        aok_reg <= aok_next;
        maddr_reg <= maddr_next;
        res_reg <= res_next;
        prod_reg <= W'(dv_reg * opnd);
    end
endmodule

### hdl/ttce_ctrl.sv
// Controller: sequences one item through read, address, memory, execute, divide wait, commit, output.
// Depends on ttce_pkg.
`timescale 1ns / 1ps
module ttce_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               clr_busy,
    input  ttce_pkg::ttce_sts_t sts,
    output ttce_pkg::ttce_cmd_t cmd
);
    import ttce_pkg::*;
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_READ = 8'b00000010, S_ADDR = 8'b00000100,
        S_MEM = 8'b00001000, S_EXEC = 8'b00010000, S_DIV = 8'b00100000,
        S_COMMIT = 8'b01000000, S_OUT = 8'b10000000
    } state_t;
    state_t state_reg, state_next;
    logic   divw_reg, divw_next;

    assign in_ready = (state_reg == S_IDLE) && !clr_busy;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        divw_next = divw_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !clr_busy)
                begin
                    cmd.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_ADDR;
            S_ADDR:
            begin
                cmd.addr = 1'b1;
                state_next = S_MEM;
            end
            S_MEM: state_next = S_EXEC;
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.div_start = sts.is_div;
                divw_next = sts.is_div;
                state_next = sts.is_div ? S_DIV : S_COMMIT;
            end
            S_DIV:
            begin
                divw_next = 1'b0;
                if (!divw_reg && !sts.div_busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // result fields are live from registers; commit on handshake
                if (out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            divw_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            divw_reg <= divw_next;
        end
    end
endmodule

### hdl/two_thread_toy_cpu_execute_top.sv
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | thread, func, dest_reg, src_reg, immediate, instr_word, in_value
// m_axis  | out | out_thread, next_pc, action, action_value, compare_flag, error
// An item passes the read, address, memory, execute, commit and output states, and the
// next is taken only after its result; divide waits on the one-bit-per-cycle divider.
// After reset the data memory is cleared word by word; no item is taken then.
// Output stalls hold the block; state commits when the result item is taken.
// Depends on ttce_pkg, ttce_ctrl, ttce_dp.
`timescale 1ns / 1ps
module two_thread_toy_cpu_execute_top #(
    parameter int DATA_DEPTH = ttce_pkg::DATA_DEPTH_DEF,
    parameter int WORD_WIDTH = ttce_pkg::WORD_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // thread, func, dest_reg, src_reg, immediate,
                                       // instr_word, in_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // out_thread, next_pc, action, action_value,
                                       // compare_flag, error
);
    import ttce_pkg::*;
    ttce_cmd_t cmd;
    ttce_sts_t sts;
    logic      clr_busy;

    ttce_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .clr_busy(clr_busy),
        .sts(sts), .cmd(cmd)
    );

    ttce_dp #(.DATA_DEPTH(DATA_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(s_axis_tdata),
        .out_data(m_axis_tdata), .clr_busy(clr_busy)
    );
endmodule
